/* rtl/iir_bandpass_fixed_order10_unit_defines.svh */
// Assertion macros used by the filter top level.
`ifndef IIR_BANDPASS_FIXED_ORDER10_UNIT_DEFINES_SVH
`define IIR_BANDPASS_FIXED_ORDER10_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define IIRBP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("iirbp: assertion failed");
`define IIRBP_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("iirbp: reset assertion failed");
`else
`define IIRBP_ASSERT(lbl, clk, rst_n, prop)
`define IIRBP_ASSERT_RST(lbl, clk, prop)
`endif
`endif

/* rtl/iirbp_pkg.sv */
`default_nettype none

package iirbp_pkg;

    localparam int ORDER    = 10;
    localparam int SMP_W    = 32;
    localparam int COEF_W   = 24;
    localparam int PROD_W   = SMP_W + COEF_W;
    localparam int ACC_W    = 64;
    localparam int DIV_W    = 24;
    localparam int QUOT_W   = SMP_W - 1;
    localparam int STEP_W   = $clog2(2 * ORDER + 1);
    localparam int TAP_W    = $clog2(ORDER + 1);

    localparam logic [DIV_W-1:0] DIVISOR = 24'd9558160;

    // The divisor is sixteen times an odd base. The quotient is estimated from
    // the top bits of the magnitude with a 32-bit reciprocal of the base, which
    // lands at most two below the true quotient; the remainder fixes it up.
    localparam int PRE_SHIFT = 4;
    localparam int EST_SHIFT = 23;
    localparam int BASE_W    = 20;
    localparam int NUM_W     = 52;
    localparam int REM_W     = 22;

    localparam logic [BASE_W-1:0] DIV_BASE  = BASE_W'(DIVISOR >> PRE_SHIFT);
    localparam logic [SMP_W-1:0]  DIV_RECIP =
        SMP_W'((64'd1 << (EST_SHIFT - PRE_SHIFT + SMP_W)) / 64'(DIV_BASE));
    localparam logic [REM_W-1:0]  REM_ONE   = REM_W'(DIV_BASE);
    localparam logic [REM_W-1:0]  REM_TWO   = REM_W'({DIV_BASE, 1'b0});

    localparam logic signed [SMP_W-1:0] SMP_MAX = 32'sh7fffffff;
    localparam logic signed [SMP_W-1:0] SMP_MIN = 32'sh80000000;

    localparam logic signed [COEF_W-1:0] FF_COEF [ORDER+1] = '{
        24'sd597385, 24'sd0, -24'sd2986929, 24'sd0, 24'sd5973856, 24'sd0,
        -24'sd5973857, 24'sd0, 24'sd2986928, 24'sd0, -24'sd597386
    };

    localparam logic signed [COEF_W-1:0] FB_COEF [ORDER+1] = '{
        24'sd1048576, -24'sd959659, -24'sd3650400, 24'sd2700937, 24'sd5580616,
        -24'sd3022504, -24'sd4541085, 24'sd1561834, 24'sd1933496,
        -24'sd311478, -24'sd340338
    };

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    first_of_block;
        logic                    last_of_block;
    } iirbp_in_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] filtered;
        logic                    last_out;
    } iirbp_out_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic signed [SMP_W-1:0] result;
    } hist_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_ROTATE,
        CELL_PUSH
    } cell_op_t;

    // Step 0 weights the new sample, steps 1 to ORDER the input history and
    // the remaining steps the output history with the feedback sign folded in.
    function automatic logic signed [COEF_W-1:0] coef_for_step(input logic [STEP_W-1:0] step);
        logic signed [COEF_W-1:0] c;
        if (step <= STEP_W'(ORDER)) begin
            c = FF_COEF[step[TAP_W-1:0]];
        end else if (step <= STEP_W'(2 * ORDER)) begin
            c = -FB_COEF[TAP_W'(step - STEP_W'(ORDER))];
        end else begin
            c = '0;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/iirbp_cell.sv */
`default_nettype none

module iirbp_cell
    import iirbp_pkg::*;
(
    input  wire           aclk,
    input  wire           aresetn,
    input  wire cell_op_t op,
    input  wire hist_t    from_prev,
    input  wire hist_t    from_next,
    output hist_t         tap
);

    hist_t hist_reg;
    hist_t hist_next;

    always_comb begin
        case (op)
            CELL_CLEAR:  hist_next = '0;
            CELL_ROTATE: hist_next = from_next;
            CELL_PUSH:   hist_next = from_prev;
            default:     hist_next = hist_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else begin
            hist_reg <= hist_next;
        end
    end

    assign tap = hist_reg;

endmodule

`default_nettype wire

/* rtl/iirbp_div.sv */
`default_nettype none

module iirbp_div
    import iirbp_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     start,
    input  wire signed [ACC_W-1:0]  dividend,
    output logic                    done,
    output logic signed [SMP_W-1:0] quotient
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_EST,
        D_FIX,
        D_FIN
    } dstate_t;

    dstate_t                 dstate_reg, dstate_next;
    logic [ACC_W-1:0]        mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic                    sat_reg, sat_next;
    logic [SMP_W-1:0]        est_reg, est_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic signed [SMP_W-1:0] quot_reg, quot_next;
    logic                    done_reg, done_next;

    logic [SMP_W-1:0]   num_hi;
    logic [NUM_W-1:0]   num;
    logic [2*SMP_W-1:0] est_prod;
    logic [NUM_W-1:0]   back_prod;
    logic [NUM_W-1:0]   diff;
    logic [1:0]         adj;
    logic [SMP_W-1:0]   q_abs;

    assign num_hi    = mag_reg[EST_SHIFT+SMP_W-1:EST_SHIFT];
    assign num       = mag_reg[PRE_SHIFT+NUM_W-1:PRE_SHIFT];
    assign est_prod  = (2*SMP_W)'(num_hi) * (2*SMP_W)'(DIV_RECIP);
    assign back_prod = NUM_W'(est_reg) * NUM_W'(DIV_BASE);
    assign diff      = num - back_prod;
    assign adj       = (rem_reg >= REM_TWO) ? 2'd2 : ((rem_reg >= REM_ONE) ? 2'd1 : 2'd0);
    assign q_abs     = est_reg + SMP_W'(adj);

    always_comb begin
        dstate_next = dstate_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        sat_next    = sat_reg;
        est_next    = est_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        done_next   = 1'b0;
        case (dstate_reg)
            D_IDLE: begin
                if (start) begin
                    neg_next    = dividend[ACC_W-1];
                    mag_next    = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
                    dstate_next = D_EST;
                end
            end
            D_EST: begin
                sat_next    = mag_reg[ACC_W-1:QUOT_W] >= (ACC_W - QUOT_W)'(DIVISOR);
                est_next    = est_prod[2*SMP_W-1:SMP_W];
                dstate_next = D_FIX;
            end
            D_FIX: begin
                rem_next    = diff[REM_W-1:0];
                dstate_next = D_FIN;
            end
            D_FIN: begin
                if (sat_reg) begin
                    quot_next = neg_reg ? SMP_MIN : SMP_MAX;
                end else if (neg_reg) begin
                    quot_next = -$signed(q_abs);
                end else begin
                    quot_next = $signed(q_abs);
                end
                done_next   = 1'b1;
                dstate_next = D_IDLE;
            end
            default: dstate_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dstate_reg <= D_IDLE;
            done_reg   <= 1'b0;
        end else begin
            dstate_reg <= dstate_next;
            done_reg   <= done_next;
            mag_reg    <= mag_next;
            neg_reg    <= neg_next;
            sat_reg    <= sat_next;
            est_reg    <= est_next;
            rem_reg    <= rem_next;
            quot_reg   <= quot_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

/* rtl/iir_bandpass_fixed_order10_unit.sv */
// One request is processed at a time: s_ready is high only in the idle state, which
// is left for the 21-step multiply-accumulate that rotates the history cells past one
// multiplier and the reciprocal divider, and re-entered once m_data is loaded.
// Reset (aresetn low, synchronous) clears both histories, the sequencer and m_valid.
// A request with first_of_block set clears both histories before it is filtered.
`default_nettype none
`include "iir_bandpass_fixed_order10_unit_defines.svh"

module iir_bandpass_fixed_order10_unit
    import iirbp_pkg::*;
#(
    parameter int FILTER_ORDER = ORDER
) (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_valid,
    output logic           s_ready,
    input  wire iirbp_in_t s_data,
    output logic           m_valid,
    input  wire            m_ready,
    output iirbp_out_t     m_data
);

    localparam int LAST_STEP = 2 * FILTER_ORDER;
    localparam int STEP_BITS = $clog2(LAST_STEP + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic [STEP_BITS-1:0]     step_reg, step_next;
    logic signed [SMP_W-1:0]  x_reg, x_next;
    logic                     last_reg, last_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     prod_vld_reg, prod_vld_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     m_valid_reg, m_valid_next;
    iirbp_out_t               m_data_reg, m_data_next;

    logic signed [SMP_W-1:0]  op_sel;
    logic signed [COEF_W-1:0] coef;
    cell_op_t                 cell_op;
    logic                     div_start;
    logic                     div_done;
    logic signed [SMP_W-1:0]  div_quot;
    hist_t                    push_val;
    hist_t                    taps [FILTER_ORDER];

    assign push_val = '{sample: x_reg, result: div_quot};

    for (genvar k = 0; k < FILTER_ORDER; k++) begin : g_cell
        hist_t prev_val;
        hist_t next_val;
        if (k == 0) begin : g_head
            assign prev_val = push_val;
        end else begin : g_body
            assign prev_val = taps[k-1];
        end
        if (k == FILTER_ORDER - 1) begin : g_tail
            assign next_val = taps[0];
        end else begin : g_link
            assign next_val = taps[k+1];
        end
        iirbp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (cell_op),
            .from_prev (prev_val),
            .from_next (next_val),
            .tap       (taps[k])
        );
    end

    iirbp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign coef = coef_for_step(STEP_W'(step_reg));

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        x_next        = x_reg;
        last_next     = last_reg;
        prod_vld_next = 1'b0;
        acc_next      = acc_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        cell_op       = CELL_HOLD;
        div_start     = 1'b0;

        if (step_reg == '0) begin
            op_sel = x_reg;
        end else if (step_reg <= STEP_BITS'(FILTER_ORDER)) begin
            op_sel = taps[0].sample;
        end else begin
            op_sel = taps[0].result;
        end
        prod_next = PROD_W'(op_sel) * PROD_W'(coef);

        if (prod_vld_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x_next     = s_data.sample;
                    last_next  = s_data.last_of_block;
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = ST_MAC;
                    if (s_data.first_of_block) begin
                        cell_op = CELL_CLEAR;
                    end
                end
            end
            ST_MAC: begin
                prod_vld_next = 1'b1;
                if (step_reg != '0) begin
                    cell_op = CELL_ROTATE;
                end
                if (step_reg == STEP_BITS'(LAST_STEP)) begin
                    state_next = ST_DRAIN;
                end else begin
                    step_next = step_reg + STEP_BITS'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_START;
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_data_next.filtered = div_quot;
                    m_data_next.last_out = last_reg;
                    cell_op              = CELL_PUSH;
                    state_next           = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prod_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            prod_vld_reg <= prod_vld_next;
            m_valid_reg  <= m_valid_next;
            step_reg     <= step_next;
            x_reg        <= x_next;
            last_reg     <= last_next;
            prod_reg     <= prod_next;
            acc_reg      <= acc_next;
            m_data_reg   <= m_data_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `IIRBP_ASSERT(a_accept_starts_mac, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == ST_MAC && step_reg == '0))
    `IIRBP_ASSERT(a_done_only_in_div, aclk, aresetn, div_done |-> (state_reg == ST_DIV))
    `IIRBP_ASSERT(a_step_in_range, aclk, aresetn, (state_reg == ST_MAC) |-> (step_reg <= STEP_BITS'(LAST_STEP)))
    `IIRBP_ASSERT(a_push_gives_result, aclk, aresetn, (cell_op == CELL_PUSH) |=> m_valid)
    `IIRBP_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> (!m_valid && s_ready))

endmodule

`default_nettype wire
